FILE: src/cb32_pkg.sv
// ----------------------------------------------------------------------------
// cb32_pkg: shared types and functions of the checked Base32 encoder
// Beat types of both channels, the symbol group passed between the encode
// and emit stages, CRC-16 step, divide-by-five and Base32 alphabet mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package cb32_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned MAX_SYMS   = 8;
    localparam int unsigned SYM_W      = 5;
    localparam int unsigned SYM_IDX_W  = $clog2(MAX_SYMS);
    localparam int unsigned SYM_CNT_W  = $clog2(MAX_SYMS + 1);

    // Register index decoded from paddr[CFG_ADDR_W-1].
    localparam logic REG_VERSION = 1'b0;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam logic [6:0] ASCII_A   = 7'd65;
    localparam logic [6:0] ASCII_TWO = 7'd50;
    localparam logic [4:0] DIGIT_SYM = 5'd26;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } out_item_t;

    // Symbols of one input beat, in output order from index 0.
    typedef struct packed {
        logic [MAX_SYMS-1:0][SYM_W-1:0] syms;
        logic [SYM_CNT_W-1:0]           count;
        logic                           frame_end;
    } sym_group_t;

    // One byte through the CRC-16, MSB first, no reflection.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Quotient by five through a reciprocal multiply; exact for 0..39.
    function automatic logic [2:0] div5(input logic [5:0] t);
        logic [11:0] p;
        p = {6'b0, t} * 12'd13;
        return p[8:6];
    endfunction

    function automatic logic [6:0] sym_to_ascii(input logic [4:0] sym);
        logic [6:0] ch;
        if (sym < DIGIT_SYM) begin
            ch = ASCII_A + {2'b00, sym};
        end
        else begin
            ch = ASCII_TWO + {2'b00, sym - DIGIT_SYM};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: src/cb32_cfg.sv
// ----------------------------------------------------------------------------
// cb32_cfg: configuration register file
// APB-style slave holding the version byte placed at the head of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cb32_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cb32_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    output logic      [7:0]                      version
);

    logic [7:0] version_reg;
    logic       wr_en;
    logic       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[cb32_pkg::CFG_ADDR_W-1];
    assign wr_en   = psel && penable && pwrite && pready;
    assign version = version_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            version_reg <= 8'h00;
        end
        else if (wr_en && (reg_idx == cb32_pkg::REG_VERSION)) begin
            version_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            cb32_pkg::REG_VERSION: prdata = {24'h0, version_reg};
            default:               prdata = 32'h0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/cb32_core.sv
// ----------------------------------------------------------------------------
// cb32_core: input register, frame state and symbol slicing
// Registers one input beat, then in a single pass works out the CRC, the
// byte string of the beat, and its 5-bit Base32 symbols including the
// zero-filled flush symbol at the frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module cb32_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire cb32_pkg::in_item_t   in_item,
    input  wire logic [7:0]           version,
    output logic                      grp_valid,
    input  wire logic                 grp_stall,
    output cb32_pkg::sym_group_t      grp
);

    logic                in_valid_reg;
    cb32_pkg::in_item_t  in_item_reg;

    logic [15:0] crc_reg,  crc_next;
    logic [3:0]  left_bits_reg, left_bits_next;
    logic [2:0]  left_cnt_reg,  left_cnt_next;
    logic        started_reg, started_next;

    logic        open_frame;
    logic        last;
    logic        advance;
    logic [2:0]  cur_cnt;
    logic [3:0]  cur_bits;
    logic [15:0] crc_ver;
    logic [15:0] crc_data;
    logic [31:0] bytes_w;
    logic [2:0]  n_bytes;
    logic [5:0]  total_bits;
    logic [43:0] stream_wide;
    logic [43:0] stream_shift;
    logic [39:0] stream;
    logic [2:0]  n_full;
    logic [5:0]  rem_wide;
    logic [2:0]  rem;
    logic [4:0]  part_sym;

    assign in_stall  = in_valid_reg && grp_stall;
    assign grp_valid = in_valid_reg;
    assign advance   = in_valid_reg && !grp_stall;

    assign open_frame = !started_reg;
    assign last       = in_item_reg.last_byte;
    assign cur_cnt    = open_frame ? 3'd0 : left_cnt_reg;
    assign cur_bits   = open_frame ? 4'd0 : left_bits_reg;

    assign crc_ver  = open_frame ? cb32_pkg::crc_byte(cb32_pkg::CRC_INIT, version) : crc_reg;
    assign crc_data = cb32_pkg::crc_byte(crc_ver, in_item_reg.data_byte);

    // Bytes of this beat left aligned; the CRC goes out low byte first.
    always_comb begin
        case ({open_frame, last})
            2'b11:   bytes_w = {version, in_item_reg.data_byte, crc_data[7:0], crc_data[15:8]};
            2'b10:   bytes_w = {version, in_item_reg.data_byte, 16'h0000};
            2'b01:   bytes_w = {in_item_reg.data_byte, crc_data[7:0], crc_data[15:8], 8'h00};
            default: bytes_w = {in_item_reg.data_byte, 24'h000000};
        endcase
    end

    assign n_bytes    = 3'd1 + {2'b00, open_frame} + {1'b0, last, 1'b0};
    assign total_bits = {3'b000, cur_cnt} + {n_bytes, 3'b000};

    // Leftover bits sit right aligned in a 4-bit field above the bytes; the
    // shift drops its unused upper zeros so the stream starts at bit 39.
    assign stream_wide  = {cur_bits, bytes_w, 8'h00};
    assign stream_shift = stream_wide << (3'd4 - cur_cnt);
    assign stream       = stream_shift[43:4];

    assign n_full   = cb32_pkg::div5(total_bits);
    assign rem_wide = total_bits - ({1'b0, n_full, 2'b00} + {3'b000, n_full});
    assign rem      = rem_wide[2:0];

    always_comb begin
        for (int k = 0; k < cb32_pkg::MAX_SYMS; k++) begin
            grp.syms[k] = stream[39 - 5*k -: 5];
        end
        grp.frame_end = last;
        if (last && (rem != 3'd0)) begin
            grp.count = {1'b0, n_full} + 4'd1;
        end
        else begin
            grp.count = {1'b0, n_full};
        end
    end

    // The partial symbol holds the leftover bits zero filled on the right.
    assign part_sym = stream[39 - 5*n_full -: 5];

    always_comb begin
        crc_next       = crc_reg;
        left_bits_next = left_bits_reg;
        left_cnt_next  = left_cnt_reg;
        started_next   = started_reg;
        if (advance) begin
            if (last) begin
                crc_next       = cb32_pkg::CRC_INIT;
                left_bits_next = 4'd0;
                left_cnt_next  = 3'd0;
                started_next   = 1'b0;
            end
            else begin
                crc_next       = crc_data;
                left_bits_next = part_sym[4:1] >> (3'd4 - rem);
                left_cnt_next  = rem;
                started_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            crc_reg       <= cb32_pkg::CRC_INIT;
            left_bits_reg <= 4'd0;
            left_cnt_reg  <= 3'd0;
            started_reg   <= 1'b0;
        end
        else begin
            if (!in_stall) begin
                in_valid_reg <= in_valid;
            end
            crc_reg       <= crc_next;
            left_bits_reg <= left_bits_next;
            left_cnt_reg  <= left_cnt_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && !in_stall) begin
            in_item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: src/cb32_emit.sv
// ----------------------------------------------------------------------------
// cb32_emit: symbol group register and character output register
// Holds the symbols of one beat and hands them out one character a cycle
// while the output is not stalled, flagging the final character of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cb32_emit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   grp_valid,
    output logic                        grp_stall,
    input  wire cb32_pkg::sym_group_t   grp,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output cb32_pkg::out_item_t         out_item
);

    logic                              grp_valid_reg;
    cb32_pkg::sym_group_t              grp_reg;
    logic [cb32_pkg::SYM_IDX_W-1:0]    idx_reg;
    logic                              out_valid_reg;
    cb32_pkg::out_item_t               out_item_reg;

    logic out_load;
    logic char_take;
    logic at_last_sym;
    logic grp_done;
    logic grp_load;

    assign out_load    = !out_valid_reg || !out_stall;
    assign char_take   = grp_valid_reg && out_load;
    assign at_last_sym = ({1'b0, idx_reg} == (grp_reg.count - 4'd1));
    assign grp_done    = char_take && at_last_sym;
    assign grp_stall   = grp_valid_reg && !grp_done;
    assign grp_load    = grp_valid && !grp_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (grp_load) begin
                grp_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (grp_done) begin
                grp_valid_reg <= 1'b0;
            end
            else if (char_take) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= char_take;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (grp_load) begin
            grp_reg <= grp;
        end
        if (char_take) begin
            out_item_reg.out_char  <= cb32_pkg::sym_to_ascii(grp_reg.syms[idx_reg]);
            out_item_reg.last_char <= grp_reg.frame_end && at_last_sym;
        end
    end

endmodule

`default_nettype wire

FILE: src/checked_base32_encoder.sv
// ----------------------------------------------------------------------------
// checked_base32_encoder: CRC-16 checked Base32 frame encoder
// Prefixes each frame with the version byte, appends the CRC-16/XMODEM of
// version and payload, and emits the frame as unpadded Base32 characters.
//
//   channel | direction | handshake           | beat
//   --------+-----------+---------------------+------------------------------
//   in      | to block  | in_valid / in_stall | data_byte, last_byte
//   out     | from block| out_valid/out_stall | out_char, last_char
//   cfg     | to block  | APB psel/penable    | version register at address 0
//
// One character leaves per cycle from a single output register while the output
// is not stalled. An input beat yields 1 to 2 characters inside a frame,
// 3 when it opens a frame, 5 to 7 when it closes one.
// An accepted beat reaches the output through the group and output registers.
// Reset clears the frame state and the version byte to zero.
// A stalled output holds its character; input is taken while a finished
// character still waits, as long as the symbol group register can be freed.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_base32_encoder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire cb32_pkg::in_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output cb32_pkg::out_item_t                  out_item,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cb32_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);

    logic                  grp_valid;
    logic                  grp_stall;
    cb32_pkg::sym_group_t  grp;
    logic [7:0]            version;

    cb32_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .version (version)
    );

    cb32_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .version   (version),
        .grp_valid (grp_valid),
        .grp_stall (grp_stall),
        .grp       (grp)
    );

    cb32_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp_stall (grp_stall),
        .grp       (grp),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Every character is in the Base32 alphabet.
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_item.out_char >= 7'd65 && out_item.out_char <= 7'd90) ||
                       (out_item.out_char >= 7'd50 && out_item.out_char <= 7'd55)))
        else $error("output character outside the Base32 alphabet");

    // A beat inside a frame carries at most 16 bits of stream: 1 to 3 symbols.
    a_mid_count: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid && !grp.frame_end) |-> (grp.count >= 4'd1 && grp.count <= 4'd3))
        else $error("symbol count of a mid-frame beat out of range");

    // A closing beat carries the CRC as well: 5 to 7 symbols; the check allows up to 8.
    a_end_count: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid && grp.frame_end) |-> (grp.count >= 4'd5 && grp.count <= 4'd8))
        else $error("symbol count of a frame-end beat out of range");

    // A group is never overwritten while the output side holds it.
    a_grp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid && grp_stall) |=> grp_valid)
        else $error("symbol group dropped while stalled");

endmodule

`default_nettype wire

FILE: dv/tb_checked_base32_encoder.sv
// ----------------------------------------------------------------------------
// tb_checked_base32_encoder: testbench of the checked Base32 frame encoder
// A short table of directed beats and register writes opens the run. Random
// frames with random idling on both channels follow. Every accepted input
// beat is run through a local frame encoder (version prefix, CRC-16 and
// Base32). The characters that leave the block are compared in order with
// the characters that this encoder predicts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_checked_base32_encoder;

    localparam logic [2:0]  VERSION_ADDR  = 3'd0;
    localparam logic [2:0]  UNMAPPED_ADDR = 3'd4;
    localparam logic [15:0] CRC16_POLY    = 16'h1021;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          PHASE_BEATS   = 45;
    localparam int          PHASES        = 8;

    typedef enum logic [1:0] {ROW_BEAT, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [2:0]  addr;
        logic [31:0] value;
        string       typed;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    cb32_pkg::in_item_t   in_item;
    logic                 out_valid;
    logic                 out_stall;
    cb32_pkg::out_item_t  out_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // Local copy of the encoder state and of the version register.
    logic [15:0] frame_crc;
    logic [3:0]  spare_bits;
    int          spare_count;
    logic        in_frame;
    logic [7:0]  version_copy;

    cb32_pkg::out_item_t  expected_chars[$];
    stim_row_t            directed_rows[$];
    string                b32_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
    int                   mismatches = 0;
    int                   hold_asked = 0;
    int                   hold_served = 0;
    logic                 calm = 1'b0;

    checked_base32_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s, got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic [6:0] b32_char(input logic [4:0] sym);
        return 7'(b32_alphabet[sym]);
    endfunction

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Adds one frame byte to the CRC and cuts whole 5-bit groups from the
    // leftover bits and the new byte, MSB first.
    function automatic void encode_frame_byte(input logic [7:0] b,
                                              ref cb32_pkg::out_item_t chars[$]);
        logic [11:0]          acc;
        int                   nbits;
        cb32_pkg::out_item_t  ch;
        acc = {spare_bits, b};
        nbits = spare_count + 8;
        frame_crc = crc16_step(frame_crc, b);
        while (nbits >= 5) begin
            nbits -= 5;
            ch.out_char = b32_char(5'(acc >> nbits));
            ch.last_char = 1'b0;
            chars = {chars, ch};
            acc &= (12'd1 << nbits) - 12'd1;
        end
        spare_bits = acc[3:0];
        spare_count = nbits;
    endfunction

    function automatic void encode_beat(input cb32_pkg::in_item_t beat,
                                        ref cb32_pkg::out_item_t chars[$]);
        logic [15:0]          crc_snap;
        logic [4:0]           flush_sym;
        cb32_pkg::out_item_t  ch;
        chars = {};
        if (!in_frame) begin
            frame_crc = 16'h0000;
            spare_bits = 4'h0;
            spare_count = 0;
            encode_frame_byte(version_copy, chars);
            in_frame = 1'b1;
        end
        encode_frame_byte(beat.data_byte, chars);
        if (beat.last_byte) begin
            crc_snap = frame_crc;
            encode_frame_byte(crc_snap[7:0], chars);
            encode_frame_byte(crc_snap[15:8], chars);
            if (spare_count > 0) begin
                flush_sym = 5'(spare_bits) << (5 - spare_count);
                ch.out_char = b32_char(flush_sym);
                ch.last_char = 1'b0;
                chars = {chars, ch};
            end
            chars[chars.size() - 1].last_char = 1'b1;
            frame_crc = 16'h0000;
            spare_bits = 4'h0;
            spare_count = 0;
            in_frame = 1'b0;
        end
    endfunction

    // Offers one beat, waits until the block takes it, then queues the
    // characters it must cause. A typed string overrides the prediction.
    task automatic send_beat(input cb32_pkg::in_item_t beat, input string typed);
        cb32_pkg::out_item_t  chars[$];
        cb32_pkg::out_item_t  ch;
        while (!calm && $urandom_range(99) < 23) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= beat;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        encode_beat(beat, chars);
        if (typed.len() != 0) begin
            chars = {};
            for (int i = 0; i < typed.len(); i++) begin
                ch.out_char = 7'(typed[i]);
                ch.last_char = beat.last_byte && (i == typed.len() - 1);
                chars = {chars, ch};
            end
        end
        expected_chars = {expected_chars, chars};
    endtask

    task automatic wait_drained(input int settle);
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_chars.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        if (addr == VERSION_ADDR) begin
            version_copy = value[7:0];
        end
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= VERSION_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        if (prdata[7:0] !== version_copy) begin
            report_mismatch("version register read back", prdata[7:0], version_copy);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void add_beat(input logic [7:0] b, input logic last, input string typed);
        stim_row_t row;
        row = '{ROW_BEAT, b, last, VERSION_ADDR, 32'h0, typed};
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_write(input logic [2:0] addr, input logic [31:0] value);
        stim_row_t row;
        row = '{ROW_WRITE, 8'h00, 1'b0, addr, value, ""};
        directed_rows = {directed_rows, row};
    endfunction

    // Output side: checks each accepted character and decides the stall of
    // the next cycle. A hold request stalls the output for a long stretch.
    initial begin
        cb32_pkg::out_item_t  want;
        int                   hold;
        hold = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("character with nothing pending", out_item.out_char, 0);
                end
                else begin
                    want = expected_chars.pop_front();
                    if (out_item.out_char !== want.out_char) begin
                        report_mismatch("out_char", out_item.out_char, want.out_char);
                    end
                    if (out_item.last_char !== want.last_char) begin
                        report_mismatch("last_char", out_item.last_char, want.last_char);
                    end
                end
            end
            if (hold_served != hold_asked) begin
                hold_served++;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                hold--;
            end
            else if (calm) begin
                out_stall <= 1'b0;
            end
            else begin
                out_stall <= ($urandom_range(99) < 23);
            end
        end
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        cb32_pkg::in_item_t  beat;
        logic [7:0]          ver;
        logic [31:0]         wval;
        int                  frame_left;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= VERSION_ADDR;
        pwdata <= 32'h0;
        frame_crc = 16'h0000;
        spare_bits = 4'h0;
        spare_count = 0;
        in_frame = 1'b0;
        version_copy = 8'h00;
        frame_left = 0;

        // Version 0 after reset: all-zero frames give plain runs of 'A'.
        add_beat(8'h00, 1'b1, "AAAAAAA");
        add_beat(8'h00, 1'b0, "AAA");
        add_beat(8'h00, 1'b1, "AAAAA");
        add_beat(8'hFF, 1'b0, "AD7");
        add_beat(8'hFF, 1'b0, "7");
        add_beat(8'hFF, 1'b1, "");
        add_write(VERSION_ADDR, 32'h0000_00FF);
        add_beat(8'h00, 1'b1, "");
        add_beat(8'hFF, 1'b1, "");
        // A write to an unmapped register must leave the version alone.
        add_write(UNMAPPED_ADDR, 32'h0000_0012);
        add_beat(8'h5A, 1'b1, "");
        add_beat(8'hAA, 1'b0, "");
        // Written inside a frame, so the new version waits for the next frame.
        add_write(VERSION_ADDR, 32'hFFFF_FFA5);
        add_beat(8'h55, 1'b0, "");
        add_beat(8'h01, 1'b1, "");
        add_beat(8'h80, 1'b1, "");
        add_write(VERSION_ADDR, 32'h0000_0000);
        add_beat(8'h7F, 1'b0, "");
        add_beat(8'hFE, 1'b0, "");
        add_beat(8'h01, 1'b0, "");
        add_beat(8'h80, 1'b1, "");
        add_beat(8'h00, 1'b1, "");

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_drained(SETTLE_CYCLES);
                cfg_write(directed_rows[i].addr, directed_rows[i].value);
            end
            else begin
                beat.data_byte = directed_rows[i].data_byte;
                beat.last_byte = directed_rows[i].last_byte;
                send_beat(beat, directed_rows[i].typed);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained(SETTLE_CYCLES);
            case (p)
                0:       ver = 8'h00;
                1:       ver = 8'hFF;
                default: ver = 8'($urandom_range(255));
            endcase
            if (p == 2 || p == 6) begin
                cfg_write(UNMAPPED_ADDR, $urandom());
            end
            wval = ($urandom() & 32'hFFFF_FF00) | {24'h0, ver};
            cfg_write(VERSION_ADDR, wval);
            calm = (p == 3);
            if (p == 5) begin
                hold_asked++;
            end
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if (frame_left == 0) begin
                    if ($urandom_range(7) == 0) begin
                        frame_left = $urandom_range(24, 7);
                    end
                    else begin
                        frame_left = $urandom_range(6, 1);
                    end
                end
                beat.data_byte = 8'($urandom_range(255));
                beat.last_byte = (frame_left == 1);
                frame_left--;
                send_beat(beat, "");
            end
        end
        calm = 1'b0;

        wait_drained(SETTLE_CYCLES);
        if (expected_chars.size() != 0) begin
            report_mismatch("characters never arrived", expected_chars.size(), 0);
        end
        if (mismatches == 0) begin
            $display("simulation ok");
        end
        else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
